[hdl/swcd_pkg.sv]
// ----------------------------------------------------------------------------
// swcd_pkg: shared definitions for the sensor word CRC deframer
// Widths, CRC-8 constants, sentinels and the result record passed from the
// frame controller to the output register.
// ----------------------------------------------------------------------------
package swcd_pkg;

    // Frame layout
    localparam int WORDS  = 9;
    localparam int IDX_W  = 4;
    localparam int MASK_W = 9;

    localparam logic [MASK_W-1:0] MASK_RESET = 9'd240;

    // CRC-8, polynomial x^8 + x^5 + x^4 + 1, no reflection, no final xor
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Word values meaning "not available"
    localparam logic [15:0] SENT_SIGNED   = 16'h7FFF;
    localparam logic [15:0] SENT_UNSIGNED = 16'hFFFF;

    // Byte position within a triple
    localparam logic [1:0] PH_HIGH = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_CRC  = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0] word_index;
        logic [15:0]      word_value;
        logic             unavailable;
        logic             crc_error;
        logic             last;
    } t_result;

endpackage

[hdl/swcd_crc8.sv]
// ----------------------------------------------------------------------------
// swcd_crc8: one-byte CRC-8 update
// Folds one data byte into a running CRC, all eight bit steps unrolled.
// ----------------------------------------------------------------------------
module swcd_crc8
    import swcd_pkg::*;
(
    input  logic [7:0] i_crc,
    input  logic [7:0] i_data,
    output logic [7:0] o_crc
);

    logic [7:0] v_crc;

    // Shift out eight bits, xor in the polynomial on a carry
    always_comb begin
        v_crc = i_crc ^ i_data;
        for (int k = 0; k < 8; k++) begin
            if (v_crc[7]) begin
                v_crc = {v_crc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v_crc = {v_crc[6:0], 1'b0};
            end
        end
        o_crc = v_crc;
    end

endmodule

[hdl/swcd_frame_ctrl.sv]
// ----------------------------------------------------------------------------
// swcd_frame_ctrl: triple sequencer and word checker
// Tracks the byte position in the frame, runs the CRC over each word and
// forms one result per CRC byte. Stops after the last word or an error
// until the next frame start.
// ----------------------------------------------------------------------------
module swcd_frame_ctrl
    import swcd_pkg::*;
#(
    parameter int FRAME_WORDS = WORDS
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_frame_start,
    input  logic [MASK_W-1:0] i_mask,
    output logic              o_res_valid,
    output t_result           o_res
);

    logic [1:0]       r_phase, n_phase;
    logic [IDX_W-1:0] r_count, n_count;
    logic [7:0]       r_crc,   n_crc;
    logic             r_abort, n_abort;
    logic [7:0]       r_high,  n_high;
    logic [7:0]       r_low,   n_low;

    logic [1:0]       w_phase;
    logic [IDX_W-1:0] w_count;
    logic             w_abort;
    logic [7:0]       w_crc_in;
    logic [7:0]       w_crc_out;
    logic [15:0]      w_word;
    logic [15:0]      w_mask_ext;
    logic [15:0]      w_sentinel;
    logic [IDX_W:0]   w_count_inc;
    logic             w_last;
    logic             w_crc_ok;

    // A frame start clears the frame state before this byte is used
    assign w_phase = i_frame_start ? PH_HIGH : r_phase;
    assign w_count = i_frame_start ? '0 : r_count;
    assign w_abort = i_frame_start ? 1'b0 : r_abort;

    // Low byte continues the running CRC, a high byte starts from init
    assign w_crc_in = (w_phase == PH_LOW) ? r_crc : CRC_INIT;

    swcd_crc8 u_crc8 (
        .i_crc  (w_crc_in),
        .i_data (i_rx_byte),
        .o_crc  (w_crc_out)
    );

    // Word checks
    assign w_word      = {r_high, r_low};
    assign w_mask_ext  = {{(16 - MASK_W){1'b0}}, i_mask};
    assign w_sentinel  = w_mask_ext[w_count] ? SENT_SIGNED : SENT_UNSIGNED;
    assign w_count_inc = {1'b0, w_count} + 1'b1;
    assign w_last      = (w_count_inc >= (IDX_W + 1)'(FRAME_WORDS));
    assign w_crc_ok    = (i_rx_byte == r_crc);

    // Result of a CRC byte
    always_comb begin
        o_res_valid       = !w_abort && (w_phase == PH_CRC);
        o_res.word_index  = w_count;
        o_res.word_value  = w_word;
        o_res.unavailable = w_crc_ok && (w_word == w_sentinel);
        o_res.crc_error   = !w_crc_ok;
        o_res.last        = !w_crc_ok || w_last;
    end

    // Next frame state
    always_comb begin
        n_phase = w_phase;
        n_count = w_count;
        n_abort = w_abort;
        n_crc   = r_crc;
        n_high  = r_high;
        n_low   = r_low;
        if (!w_abort) begin
            unique case (w_phase)
                PH_LOW: begin
                    n_low   = i_rx_byte;
                    n_crc   = w_crc_out;
                    n_phase = PH_CRC;
                end
                PH_CRC: begin
                    if (!w_crc_ok) begin
                        n_abort = 1'b1;
                    end else begin
                        if (w_last) begin
                            n_abort = 1'b1;
                        end else begin
                            n_count = w_count_inc[IDX_W-1:0];
                        end
                        n_phase = PH_HIGH;
                        n_crc   = CRC_INIT;
                    end
                end
                default: begin
                    n_high  = i_rx_byte;
                    n_crc   = w_crc_out;
                    n_phase = PH_LOW;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HIGH;
            r_count <= '0;
            r_crc   <= CRC_INIT;
            r_abort <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_crc   <= n_crc;
            r_abort <= n_abort;
        end
    end

    // Held data bytes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_high <= n_high;
            r_low  <= n_low;
        end
    end

endmodule

[hdl/sensor_word_crc_deframer.sv]
// ----------------------------------------------------------------------------
// sensor_word_crc_deframer: CRC-8 checked word deframer
// Input channel: one response byte per transfer (i_rx_byte, i_frame_start),
//   accepted when i_valid is high and o_stall is low.
// Output channel: one word per good triple (index, value, unavailable flag)
//   or one error word on a CRC mismatch, accepted when o_valid is high and
//   i_stall is low. last marks the final word of a frame or an error.
// Configuration: i_cfg_we writes i_cfg_data into the signed word mask.
// Throughput: one byte per cycle while o_stall is low. A byte moves from the
//   input register through the CRC and frame logic into the output register,
//   where a CRC byte raises o_valid with its word until the word is taken.
// Stall: while a word waits in the output register under i_stall, the next
//   byte still enters the input register; a further byte is held off with
//   o_stall only if the held byte would have to produce a word too.
// Reset: clears both registers, the frame state and sets the mask to 0xF0;
//   the first byte after reset is taken as the start of a frame.
// ----------------------------------------------------------------------------
module sensor_word_crc_deframer
    import swcd_pkg::*;
#(
    parameter int FRAME_WORDS = WORDS
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [MASK_W-1:0] i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_frame_start,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [IDX_W-1:0]  o_word_index,
    output logic [15:0]       o_word_value,
    output logic              o_unavailable,
    output logic              o_crc_error,
    output logic              o_last
);

    logic [MASK_W-1:0] r_mask;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_start;
    logic              r_out_valid;
    t_result           r_out;

    logic              w_out_free;
    logic              w_proc;
    logic              w_res_valid;
    t_result           w_res;

    // Mask register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= MASK_RESET;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_data;
        end
    end

    // Process the held byte unless it makes a word with nowhere to go
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_proc     = r_in_valid && (w_out_free || !w_res_valid);
    assign o_stall    = r_in_valid && !w_proc;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte  <= i_rx_byte;
            r_in_start <= i_frame_start;
        end
    end

    swcd_frame_ctrl #(
        .FRAME_WORDS (FRAME_WORDS)
    ) u_frame_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_proc),
        .i_rx_byte     (r_in_byte),
        .i_frame_start (r_in_start),
        .i_mask        (r_mask),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_word_index  = r_out.word_index;
    assign o_word_value  = r_out.word_value;
    assign o_unavailable = r_out.unavailable;
    assign o_crc_error   = r_out.crc_error;
    assign o_last        = r_out.last;

`ifndef SYNTHESIS
    // An error word always ends the frame and is never flagged unavailable
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_crc_error) |-> (o_last && !o_unavailable))
        else $error("crc error word without last or with unavailable set");

    // A good word marked last is the final word of the frame
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_crc_error && o_last) |-> (o_word_index == IDX_W'(FRAME_WORDS - 1)))
        else $error("last word at wrong index");

    // Word index stays inside the frame
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_word_index} < (IDX_W + 1)'(FRAME_WORDS)))
        else $error("word index beyond frame");

    // A held byte that produces no word never stalls the input
    a_no_dead_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_res_valid) |-> !o_stall)
        else $error("input stalled by a byte that yields no word");
`endif

endmodule
